[sv/char_lcd_parallel_write_controller_macros.svh]
// Assertion macros for the character LCD write controller checker.
// Depends on nothing; included by the checker file only.
`ifndef CHAR_LCD_PARALLEL_WRITE_CONTROLLER_MACROS_SVH
`define CHAR_LCD_PARALLEL_WRITE_CONTROLLER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define CLCD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define CLCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/clcd_pkg.sv]
// Package for the character LCD write controller: item structs, codes, helpers.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package clcd_pkg;

    localparam int TICK_COUNT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_ADDR_BITS   = 3;

    // Request codes
    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_INIT      = 3'd1,
        ACT_WRITE_DAT = 3'd2,
        ACT_WRITE_CMD = 3'd3,
        ACT_MOVE_CUR  = 3'd4,
        ACT_CLEAR     = 3'd5
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FUNCTION_SET   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DISPLAY_CTRL   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CLEAR_CODE     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CURSOR_BASE    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ENABLE_TICKS   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SETTLE_TICKS   = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_POWER_UP_TICKS = 3'd6;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_POWER   = 3'd1,
        PH_EN      = 3'd2,
        PH_SETTLE  = 3'd3,
        PH_IEN     = 3'd4,
        PH_ISETTLE = 3'd5,
        PH_IGAP    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [3:0] column;
    } in_item_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable_pin;
        logic [7:0] data_bus;
        logic       pins_driven;
        logic       busy_res;
        logic       rejected;
    } out_item_t;

    // DDRAM row start addresses; row 3 follows row 1 at +0x10
    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h10;
            default: off = 8'h50;
        endcase
        return off;
    endfunction

    // Extra gap after each init command
    function automatic logic [1:0] init_gap(input logic [1:0] step);
        logic [1:0] gap;
        case (step)
            2'd0:    gap = 2'd1;
            2'd1:    gap = 2'd1;
            default: gap = 2'd2;
        endcase
        return gap;
    endfunction

    // Fit a 16-bit tick setting into the counter width
    function automatic logic [TICK_COUNT_BITS-1:0] cnt_load(input logic [15:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[TICK_COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/char_lcd_parallel_write_controller.sv]
// Character LCD 8-bit parallel write controller, top level.
// Depends on clcd_pkg.
//
//   channel | ports                       | moves
//   --------+-----------------------------+---------------------------------
//   input   | s_valid s_ready s_data      | one tick or request per transfer
//   result  | m_valid m_ready m_data      | pin levels after that step
//   config  | cfg_wr_en cfg_addr cfg_data | register write, no wait
//
// Each input transfer is handled at its accepting edge: the sequencer state and
// the result register update there, so one item per cycle while s_ready is high.
// The single result register is the only buffer; s_ready drops only while a
// result is held and m_ready is low.
// Reset (aresetn low, synchronous) sets defaults and an idle sequencer.
`default_nettype none

module char_lcd_parallel_write_controller
    import clcd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers
    logic [7:0]  function_set_reg, display_ctrl_reg, clear_code_reg, cursor_base_reg;
    logic [15:0] enable_ticks_reg, settle_ticks_reg, power_up_ticks_reg;

    // Sequencer state
    phase_t                     phase_reg, phase_next;
    logic [TICK_COUNT_BITS-1:0] tick_count_reg, tick_count_next;
    logic [7:0]                 held_byte_reg, held_byte_next;
    logic                       held_select_reg, held_select_next;
    logic [1:0]                 init_step_reg, init_step_next;
    logic                       outputs_enabled_reg, outputs_enabled_next;
    logic                       rejected_next;

    logic      m_valid_reg;
    out_item_t m_data_reg, m_data_next;
    logic      in_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            function_set_reg   <= 8'd56;
            display_ctrl_reg   <= 8'd15;
            clear_code_reg     <= 8'd1;
            cursor_base_reg    <= 8'd128;
            enable_ticks_reg   <= 16'd1;
            settle_ticks_reg   <= 16'd2;
            power_up_ticks_reg <= 16'd40;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FUNCTION_SET:   function_set_reg   <= cfg_data[7:0];
                CFG_DISPLAY_CTRL:   display_ctrl_reg   <= cfg_data[7:0];
                CFG_CLEAR_CODE:     clear_code_reg     <= cfg_data[7:0];
                CFG_CURSOR_BASE:    cursor_base_reg    <= cfg_data[7:0];
                CFG_ENABLE_TICKS:   enable_ticks_reg   <= cfg_data;
                CFG_SETTLE_TICKS:   settle_ticks_reg   <= cfg_data;
                CFG_POWER_UP_TICKS: power_up_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state for one step
    always_comb begin
        phase_next           = phase_reg;
        tick_count_next      = tick_count_reg;
        held_byte_next       = held_byte_reg;
        held_select_next     = held_select_reg;
        init_step_next       = init_step_reg;
        outputs_enabled_next = outputs_enabled_reg;
        rejected_next        = 1'b0;

        if (action_t'(s_data.action) == ACT_TICK) begin
            if (phase_reg != PH_IDLE) begin
                if (tick_count_reg > TICK_COUNT_BITS'(1)) begin
                    tick_count_next = tick_count_reg - TICK_COUNT_BITS'(1);
                end else begin
                    case (phase_reg)
                        PH_POWER: begin
                            init_step_next   = 2'd0;
                            held_byte_next   = function_set_reg;
                            held_select_next = 1'b0;
                            phase_next       = PH_IEN;
                            tick_count_next  = cnt_load(enable_ticks_reg);
                        end
                        PH_EN: begin
                            phase_next      = PH_SETTLE;
                            tick_count_next = cnt_load(settle_ticks_reg);
                        end
                        PH_IEN: begin
                            phase_next      = PH_ISETTLE;
                            tick_count_next = cnt_load(settle_ticks_reg);
                        end
                        PH_ISETTLE: begin
                            phase_next      = PH_IGAP;
                            tick_count_next = cnt_load(16'(init_gap(init_step_reg)));
                        end
                        PH_IGAP: begin
                            if (init_step_reg < 2'd2) begin
                                init_step_next   = init_step_reg + 2'd1;
                                held_byte_next   = (init_step_reg == 2'd0) ?
                                                   display_ctrl_reg : clear_code_reg;
                                held_select_next = 1'b0;
                                phase_next       = PH_IEN;
                                tick_count_next  = cnt_load(enable_ticks_reg);
                            end else begin
                                init_step_next  = 2'd0;
                                phase_next      = PH_IDLE;
                                tick_count_next = '0;
                            end
                        end
                        default: begin
                            // settle end, or an unused phase code
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                        end
                    endcase
                end
            end
        end else if (s_data.action <= 3'(ACT_CLEAR)) begin
            if (phase_reg != PH_IDLE) begin
                rejected_next = 1'b1;
            end else if (action_t'(s_data.action) == ACT_INIT) begin
                outputs_enabled_next = 1'b1;
                init_step_next       = 2'd0;
                phase_next           = PH_POWER;
                tick_count_next      = cnt_load(power_up_ticks_reg);
            end else begin
                phase_next       = PH_EN;
                tick_count_next  = cnt_load(enable_ticks_reg);
                held_select_next = 1'b0;
                case (action_t'(s_data.action))
                    ACT_WRITE_DAT: begin
                        held_byte_next   = s_data.byte_value;
                        held_select_next = 1'b1;
                    end
                    ACT_WRITE_CMD: held_byte_next = s_data.byte_value;
                    ACT_MOVE_CUR:  held_byte_next = (row_offset(s_data.row) +
                                                     8'(s_data.column)) | cursor_base_reg;
                    default:       held_byte_next = clear_code_reg;
                endcase
            end
        end
    end

    // Result item from the updated state
    always_comb begin
        m_data_next.reg_select  = held_select_next;
        m_data_next.read_write  = 1'b0;
        m_data_next.enable_pin  = (phase_next == PH_EN) || (phase_next == PH_IEN);
        m_data_next.data_bus    = held_byte_next;
        m_data_next.pins_driven = outputs_enabled_next;
        m_data_next.busy_res    = (phase_next != PH_IDLE);
        m_data_next.rejected    = rejected_next;
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            tick_count_reg      <= '0;
            held_byte_reg       <= '0;
            held_select_reg     <= 1'b0;
            init_step_reg       <= 2'd0;
            outputs_enabled_reg <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (in_xfer) begin
                phase_reg           <= phase_next;
                tick_count_reg      <= tick_count_next;
                held_byte_reg       <= held_byte_next;
                held_select_reg     <= held_select_next;
                init_step_reg       <= init_step_next;
                outputs_enabled_reg <= outputs_enabled_next;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

[sv/clcd_checker.sv]
// Port-level checker for the character LCD write controller, with its bind.
// Depends on clcd_pkg and char_lcd_parallel_write_controller_macros.svh.
`default_nettype none

`include "char_lcd_parallel_write_controller_macros.svh"

module clcd_checker
    import clcd_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A held result stays put until its transfer
    `CLCD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_data), "result changed while stalled")
    // RW pin never leaves write mode
    `CLCD_ASSERT_IMPL(a_rw_low, aclk, aresetn, m_valid, !m_data.read_write, "read_write high")
    // A rejected request only happens while a sequence is running
    `CLCD_ASSERT_IMPL(a_rej_busy, aclk, aresetn, m_valid && m_data.rejected,
                      m_data.busy_res, "reject while idle")
    // Enable strobe only while a sequence is running
    `CLCD_ASSERT_IMPL(a_en_busy, aclk, aresetn, m_valid && m_data.enable_pin,
                      m_data.busy_res, "enable while idle")
    // Input is never stalled unless a result waits
    `CLCD_ASSERT_ALWAYS(a_ready, aclk, aresetn, s_ready || (m_valid && !m_ready),
                        "input stalled with no result waiting")

endmodule

bind char_lcd_parallel_write_controller clcd_checker u_clcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
